// ===== design/arl_pkg.sv =====
// ----------------------------------------------------------------------------
// arl_pkg: shared types and codes for the address region lookup
// Request and response words, table entry layout, op codes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package arl_pkg;

   localparam int ADDR_W = 64;
   localparam int LEN_W  = 48;
   localparam int SLOT_W = 4;
   localparam int OP_W   = 2;

   // op codes of a request word
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [SLOT_W-1:0] entry;
      logic [ADDR_W-1:0] start_addr;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  store_base;
      logic [ADDR_W-1:0] lookup_addr;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] region;
      logic [LEN_W-1:0]  byte_offset;
      logic [LEN_W-1:0]  bytes_left;
   } rsp_type;

   // one slot of the region table
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  store_base;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic write_entry;
      logic clear_all;
      logic begin_lookup;
      logic read_step;
      logic calc;
      logic emit_result;
      logic emit_zero;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } status_type;

endpackage

// ===== design/address_region_lookup_core.sv =====
// ----------------------------------------------------------------------------
// address_region_lookup_core: address to backing store offset translation
// Region table with write, clear and lookup words; one response per word.
// ----------------------------------------------------------------------------
// Write, clear and unused words: response strobe in the cycle after accept,
//   a new word every cycle.
// Lookup: the scan reads one table slot per cycle from the single memory
//   read port; the CMP, CALC and DONE states then raise the response strobe.
// The receiver cannot stall; each response is held for one cycle only.
// Reset is synchronous and clears all valid bits at once; slot contents are
//   undefined until written.
module address_region_lookup_core #(
   parameter int REGIONS     = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  arl_pkg::req_type req_word,
   output logic             rsp_valid,
   output arl_pkg::rsp_type rsp_word
);
   import arl_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence each word
   arl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_word.op),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // table, scan and result arithmetic
   arl_datapath #(
      .REGIONS     (REGIONS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== design/arl_ctrl.sv =====
// ----------------------------------------------------------------------------
// arl_ctrl: sequencer of the address region lookup
// Takes request words, issues table writes and clears at once, and walks
// a lookup through scan, last compare, distance and result steps.
// ----------------------------------------------------------------------------
module arl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [arl_pkg::OP_W-1:0] req_op,
   output logic                   busy,
   output arl_pkg::cmd_type       cmd,
   input  arl_pkg::status_type    status
);
   import arl_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_CALC = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // decode the next state and this cycle's commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_WRITE: begin
                     cmd.write_entry = 1'b1;
                     cmd.emit_zero   = 1'b1;
                  end
                  OP_LOOKUP: begin
                     cmd.begin_lookup = 1'b1;
                     state_in         = ST_SCAN;
                  end
                  OP_CLEAR: begin
                     cmd.clear_all = 1'b1;
                     cmd.emit_zero = 1'b1;
                  end
                  default: begin
                     cmd.emit_zero = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.read_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.emit_result = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_lookup_scans: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_LOOKUP) |=> (state_ff == ST_SCAN))
      else $error("lookup word did not enter the scan");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status.scan_last) |=> (state_ff == ST_CMP))
      else $error("scan did not stop at the last slot");

   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> !busy)
      else $error("controller stayed busy after the result");

endmodule

// ===== design/arl_datapath.sv =====
// ----------------------------------------------------------------------------
// arl_datapath: region table, scan compare and result arithmetic
// Holds the table in a memory with a registered read port and the valid
// bits in flops, keeps the best candidate seen during a scan, and forms
// the store offset and bytes left of a hit.
// ----------------------------------------------------------------------------
module arl_datapath #(
   parameter int REGIONS     = 16,
   parameter int OFFSET_BITS = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  arl_pkg::req_type    req_word,
   input  arl_pkg::cmd_type    cmd,
   output arl_pkg::status_type status,
   output logic                rsp_valid,
   output arl_pkg::rsp_type    rsp_word
);
   import arl_pkg::*;

   localparam int IDX_W  = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int KEEP_W = (OFFSET_BITS < LEN_W) ? OFFSET_BITS : LEN_W;
   localparam logic [LEN_W-1:0] OFF_MASK = {LEN_W{1'b1}} >> (LEN_W - KEEP_W);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

   entry_type          region_mem_ff [REGIONS];
   logic [REGIONS-1:0] valid_ff;
   logic [REGIONS-1:0] valid_in;

   logic [IDX_W-1:0]   scan_idx_ff;
   logic [IDX_W-1:0]   scan_idx_in;
   entry_type          rd_entry_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               cmp_en_ff;
   logic               cmp_en_in;

   logic [ADDR_W-1:0]  addr_ff;
   logic               found_ff;
   logic               found_in;
   logic [IDX_W-1:0]   best_idx_ff;
   entry_type          best_ff;
   logic               take_cand;

   logic [ADDR_W-1:0]  dist_full;
   logic [LEN_W-1:0]   dist_ff;
   logic               in_range_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               slot_ok;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   logic [IDX_W-1:0]   wr_idx;
   logic [IDX_W+SLOT_W-1:0] best_ext;
   entry_type          wr_entry;

   // map the slot of a write word onto the table index
   assign slot_ok  = ({28'd0, req_word.entry} < 32'(REGIONS));
   assign slot_ext = {{IDX_W{1'b0}}, req_word.entry};
   assign wr_idx   = slot_ext[IDX_W-1:0];
   assign wr_entry = '{start_addr: req_word.start_addr,
                       length:     req_word.length,
                       store_base: req_word.store_base};

   // write a slot or read the next scan slot
   always_ff @(posedge clock) begin
      if (cmd.write_entry && slot_ok) begin
         region_mem_ff[wr_idx] <= wr_entry;
      end
      if (cmd.read_step) begin
         rd_entry_ff <= region_mem_ff[scan_idx_ff];
      end
   end

   // set or drop valid bits
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.write_entry && slot_ok) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   // advance the scan index
   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.begin_lookup) begin
         scan_idx_in = '0;
      end else if (cmd.read_step) begin
         scan_idx_in = (scan_idx_ff == LAST_IDX) ? '0 : scan_idx_ff + 1'b1;
      end
   end

   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign cmp_en_in        = cmd.read_step;

   // keep the candidate with the greatest start not above the address;
   // a strict compare keeps the lowest slot among equal starts
   assign take_cand = cmp_en_ff && rd_valid_ff
                      && (rd_entry_ff.start_addr <= addr_ff)
                      && (!found_ff || (rd_entry_ff.start_addr > best_ff.start_addr));

   always_comb begin
      found_in = found_ff;
      if (cmd.begin_lookup) begin
         found_in = 1'b0;
      end else if (take_cand) begin
         found_in = 1'b1;
      end
   end

   // distance of the address into the chosen region
   assign dist_full = addr_ff - best_ff.start_addr;

   // hold the best candidate and the lookup address
   always_ff @(posedge clock) begin
      if (cmd.begin_lookup) begin
         addr_ff <= req_word.lookup_addr;
      end
      if (cmd.read_step) begin
         rd_valid_ff <= valid_ff[scan_idx_ff];
         rd_idx_ff   <= scan_idx_ff;
      end
      if (take_cand) begin
         best_ff     <= rd_entry_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (cmd.calc) begin
         dist_ff     <= dist_full[LEN_W-1:0];
         in_range_ff <= found_ff
                        && (dist_full < {{(ADDR_W-LEN_W){1'b0}}, best_ff.length});
      end
   end

   // form the response word
   assign best_ext = {{SLOT_W{1'b0}}, best_idx_ff};

   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = cmd.emit_result || cmd.emit_zero;
      if (cmd.emit_result && in_range_ff) begin
         rsp_in.hit         = 1'b1;
         rsp_in.region      = best_ext[SLOT_W-1:0];
         rsp_in.byte_offset = (best_ff.store_base + dist_ff) & OFF_MASK;
         rsp_in.bytes_left  = best_ff.length - dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_result || cmd.emit_zero) begin
         rsp_ff <= rsp_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         scan_idx_ff  <= '0;
         cmp_en_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_en_ff    <= cmp_en_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_zero_word: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_zero |=> (rsp_valid_ff && !rsp_ff.hit && rsp_ff.bytes_left == '0))
      else $error("write or clear word gave a nonzero response");

   a_hit_has_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |-> (rsp_ff.bytes_left != '0))
      else $error("hit with no bytes left in the region");

   a_clear_drops: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |=> (valid_ff == '0))
      else $error("clear left a valid slot");

endmodule

// ===== tb/tb_address_region_lookup_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_address_region_lookup_core: self-checking bench for the region lookup
// Drives write, clear, lookup and unused-op words through the start/busy
// handshake. A scoreboard keeps its own copy of the region table and predicts
// each response word, then checks the strobed responses in order.
// ----------------------------------------------------------------------------
module tb_address_region_lookup_core;
   import arl_pkg::*;

   localparam int REGIONS      = 16;
   localparam int OFFSET_BITS  = 48;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_WORDS = 1150;
   localparam int DRAIN_CYCLES = REGIONS + 12;
   localparam int IDLE_PERCENT = 38;
   localparam int PRINT_CAP    = 200;

   // spare op code, decoded by the block as a no-op
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // --------------------------------------------------------------------------
   // Scoreboard: region table copy, response prediction and checking
   // --------------------------------------------------------------------------
   class region_scoreboard;
      logic [ADDR_W-1:0] slot_start [REGIONS];
      logic [LEN_W-1:0]  slot_length[REGIONS];
      logic [LEN_W-1:0]  slot_base  [REGIONS];
      bit                slot_valid [REGIONS];
      rsp_type           pending_rsp_q[$];
      int                error_count;

      function new();
         foreach (slot_valid[i]) slot_valid[i] = 1'b0;
         error_count = 0;
      endfunction

      // apply one word to the table copy and return its response
      function rsp_type translate_word(req_type w);
         rsp_type           r;
         logic [ADDR_W-1:0] delta;
         logic [ADDR_W-1:0] off_sum;
         logic [ADDR_W-1:0] off_mask;
         int                best;
         bit                found;
         r        = '0;
         found    = 1'b0;
         best     = 0;
         off_mask = {ADDR_W{1'b1}} >> (ADDR_W - OFFSET_BITS);
         case (w.op)
            OP_WRITE: begin
               if (w.entry < REGIONS) begin
                  slot_start[w.entry]  = w.start_addr;
                  slot_length[w.entry] = w.length;
                  slot_base[w.entry]   = w.store_base;
                  slot_valid[w.entry]  = 1'b1;
               end
            end
            OP_CLEAR: begin
               foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            end
            OP_LOOKUP: begin
               // greatest start not above the address; strict compare keeps lowest slot
               for (int i = 0; i < REGIONS; i++) begin
                  if (slot_valid[i] && slot_start[i] <= w.lookup_addr) begin
                     if (!found || slot_start[i] > slot_start[best]) begin
                        best  = i;
                        found = 1'b1;
                     end
                  end
               end
               // only the chosen region is tested for coverage
               if (found) begin
                  delta = w.lookup_addr - slot_start[best];
                  if (delta < {{(ADDR_W-LEN_W){1'b0}}, slot_length[best]}) begin
                     off_sum       = ({{(ADDR_W-LEN_W){1'b0}}, slot_base[best]} + delta)
                                     & off_mask;
                     r.hit         = 1'b1;
                     r.region      = best[SLOT_W-1:0];
                     r.byte_offset = off_sum[LEN_W-1:0];
                     r.bytes_left  = slot_length[best] - delta[LEN_W-1:0];
                  end
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(req_type w);
         rsp_type want;
         want          = translate_word(w);
         pending_rsp_q = {pending_rsp_q, want};
      endfunction

      task report_mismatch(string what);
         if (error_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
         error_count++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response word %h", got));
         end else begin
            want = pending_rsp_q.pop_front();
            compare_field("hit", 64'(got.hit), 64'(want.hit));
            compare_field("region", 64'(got.region), 64'(want.region));
            compare_field("byte_offset", 64'(got.byte_offset), 64'(want.byte_offset));
            compare_field("bytes_left", 64'(got.bytes_left), 64'(want.bytes_left));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_valid;
   rsp_type rsp_word;

   region_scoreboard region_sb = new();
   bit               idle_enabled = 1'b1;
   int               cycle_count  = 0;

   address_region_lookup_core #(
      .REGIONS     (REGIONS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // Sample both channels at the edge that ends each cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) region_sb.check_response(rsp_word);
         if (start && !busy) region_sb.note_request(req_word);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // fully random word; callers override the fields that matter
   function automatic req_type noise_word();
      req_type w;
      w.op          = OP_W'($urandom_range(3));
      w.entry       = SLOT_W'($urandom_range(REGIONS - 1));
      w.start_addr  = rand64();
      w.length      = LEN_W'(rand64());
      w.store_base  = LEN_W'(rand64());
      w.lookup_addr = rand64();
      return w;
   endfunction

   function automatic req_type write_word(int slot, logic [ADDR_W-1:0] first,
                                          logic [LEN_W-1:0] len, logic [LEN_W-1:0] base);
      req_type w;
      w            = noise_word();
      w.op         = OP_WRITE;
      w.entry      = SLOT_W'(slot);
      w.start_addr = first;
      w.length     = len;
      w.store_base = base;
      return w;
   endfunction

   function automatic req_type lookup_word(logic [ADDR_W-1:0] addr);
      req_type w;
      w             = noise_word();
      w.op          = OP_LOOKUP;
      w.lookup_addr = addr;
      return w;
   endfunction

   function automatic req_type op_word(logic [OP_W-1:0] op);
      req_type w;
      w    = noise_word();
      w.op = op;
      return w;
   endfunction

   // Hold start high until the block takes the word; idle at random first
   task automatic send_word(req_type w);
      while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_word <= w;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // random valid slot of the table copy, -1 when the table is empty
   function automatic int pick_valid_slot();
      int first;
      first = $urandom_range(REGIONS - 1);
      for (int k = 0; k < REGIONS; k++)
         if (region_sb.slot_valid[(first + k) % REGIONS]) return (first + k) % REGIONS;
      return -1;
   endfunction

   // Build a region write around a cluster so regions overlap and tie
   function automatic req_type random_region_write(logic [ADDR_W-1:0] cluster);
      logic [ADDR_W-1:0] first;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  base;
      int                peer;
      peer = pick_valid_slot();
      case ($urandom_range(5))
         0:       first = rand64();
         1:       first = ADDR_W'($urandom_range(65535));
         2:       first = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(65535));
         3:       first = (peer < 0) ? cluster : region_sb.slot_start[peer];
         4:       first = (peer < 0) ? cluster
                          : region_sb.slot_start[peer] + region_sb.slot_length[peer];
         default: first = cluster + ADDR_W'($urandom_range(4096));
      endcase
      case ($urandom_range(9))
         0:       len = '0;
         1:       len = {LEN_W{1'b1}};
         2:       len = LEN_W'(rand64());
         3, 4:    len = LEN_W'($urandom_range(1, 256));
         default: len = LEN_W'($urandom_range(1, 65535));
      endcase
      base = ($urandom_range(3) == 0) ? {LEN_W{1'b1}} - LEN_W'($urandom_range(65535))
                                      : LEN_W'(rand64());
      return write_word($urandom_range(REGIONS - 1), first, len, base);
   endfunction

   // Aim a lookup at a live region: inside, at both edges, just outside
   function automatic req_type aimed_lookup();
      logic [ADDR_W-1:0] len64;
      logic [ADDR_W-1:0] delta;
      int                s;
      s = pick_valid_slot();
      if (s < 0) return lookup_word(rand64());
      len64 = {{(ADDR_W-LEN_W){1'b0}}, region_sb.slot_length[s]};
      case ($urandom_range(7))
         0:       delta = '0;
         1:       delta = len64 - 1;
         2:       delta = len64;
         3:       delta = {ADDR_W{1'b1}};
         default: delta = (len64 == 0) ? '0 : rand64() % len64;
      endcase
      return lookup_word(region_sb.slot_start[s] + delta);
   endfunction

   task automatic run_directed();
      // empty table, spare op
      send_word(lookup_word('0));
      send_word(lookup_word({ADDR_W{1'b1}}));
      send_word(op_word(OP_UNUSED));
      // full-size region at address zero
      send_word(write_word(0, '0, {LEN_W{1'b1}}, '0));
      send_word(lookup_word('0));
      send_word(lookup_word(ADDR_W'({LEN_W{1'b1}}) - 1));
      send_word(lookup_word(ADDR_W'({LEN_W{1'b1}})));
      // top of the address space, store offset wraps
      send_word(write_word(15, {ADDR_W{1'b1}} - 15, LEN_W'(16), {LEN_W{1'b1}} - 7));
      send_word(lookup_word({ADDR_W{1'b1}}));
      // equal starts: lower slot wins and shadows the longer one
      send_word(write_word(7, ADDR_W'('h1000), LEN_W'('h100), LEN_W'('h5000)));
      send_word(write_word(3, ADDR_W'('h1000), LEN_W'('h40), LEN_W'('h9000)));
      send_word(lookup_word(ADDR_W'('h1020)));
      send_word(lookup_word(ADDR_W'('h1080)));
      // zero-length region hides the covering region below it
      send_word(write_word(9, ADDR_W'('h2000), '0, LEN_W'('h123)));
      send_word(lookup_word(ADDR_W'('h2000)));
      send_word(lookup_word(ADDR_W'('h1fff)));
      send_word(op_word(OP_UNUSED));
      send_word(lookup_word(ADDR_W'('h1000)));
      // clear drops every region
      send_word(op_word(OP_CLEAR));
      send_word(lookup_word(ADDR_W'('h1020)));
      // one-byte region at the last address
      send_word(write_word(5, {ADDR_W{1'b1}}, LEN_W'(1), {LEN_W{1'b1}}));
      send_word(lookup_word({ADDR_W{1'b1}}));
      send_word(lookup_word({ADDR_W{1'b1}} - 1));
      send_word(op_word(OP_CLEAR));
   endtask

   // Phases of region writes followed by bursts of lookups, with some noise
   task automatic run_random();
      logic [ADDR_W-1:0] cluster;
      int                sent;
      int                nwrites;
      int                nlookups;
      int                pick;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         cluster = ($urandom_range(1) == 0) ? rand64() : ADDR_W'($urandom_range(1 << 20));
         if ($urandom_range(3) == 0) begin
            send_word(op_word(OP_CLEAR));
            sent++;
         end
         nwrites = $urandom_range(1, 6);
         for (int k = 0; k < nwrites; k++) begin
            send_word(random_region_write(cluster));
            sent++;
         end
         nlookups = $urandom_range(8, 40);
         for (int k = 0; k < nlookups; k++) begin
            // no idling through a long middle stretch
            idle_enabled = !(sent >= 400 && sent < 650);
            pick = $urandom_range(99);
            if (pick < 8)       send_word(noise_word());
            else if (pick < 75) send_word(aimed_lookup());
            else if (pick < 88) send_word(lookup_word(cluster + ADDR_W'($urandom_range(8192))));
            else                send_word(lookup_word(rand64()));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      start <= 1'b0;
      // drain outstanding responses, then let the block settle
      while (region_sb.pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (region_sb.error_count == 0 && region_sb.pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
